>>> rtl/bounded_deque_macros.svh
// Assertion macros shared by the bounded deque RTL.
// Included by files that check their own logic; needs nothing else.
`ifndef BOUNDED_DEQUE_MACROS_SVH
`define BOUNDED_DEQUE_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, checked while out of reset.
`define BDQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked while out of reset.
`define BDQ_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BDQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define BDQ_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> rtl/bdq_pkg.sv
// Package for the bounded deque: sizes, command and status codes, cell controls.
// Used by the interfaces, the cell chain and the top level; depends on nothing.
`timescale 1ns / 1ps
package bdq_pkg;

    localparam int DEPTH   = 16;
    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int WORD_W  = 64;
    localparam int CMD_W   = 3;
    localparam int OCNT_W  = 5;
    localparam int STAT_W  = 2;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [CNT_W-1:0]  cnt_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD_FRONT = 3'd0,
        CMD_ADD_BACK  = 3'd1,
        CMD_REM_FRONT = 3'd2,
        CMD_REM_BACK  = 3'd3,
        CMD_REVERSE   = 3'd4,
        CMD_CLEAR     = 3'd5
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        STATUS_DONE      = 2'd0,
        STATUS_OVERFLOW  = 2'd1,
        STATUS_UNDERFLOW = 2'd2
    } status_t;

    // What one cell loads at the next edge.
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_FROM_LOWER,
        CELL_FROM_UPPER,
        CELL_LOAD
    } cell_op_t;

    // Control for the whole row, produced by the top level.
    typedef struct packed {
        logic shift_up;
        logic shift_down;
        logic put_high;
        idx_t put_idx;
        idx_t high_idx;
    } chain_ctrl_t;

endpackage

>>> rtl/bdq_cmd_if.sv
// Request channel of the bounded deque: a command and a word.
// Depends on bdq_pkg.
`timescale 1ns / 1ps
interface bdq_cmd_if;
    logic                         valid;
    logic                         ready;
    logic [bdq_pkg::CMD_W-1:0]    command;
    logic [bdq_pkg::WORD_W-1:0]   value;

    modport source (output valid, output command, output value, input ready);
    modport sink   (input valid, input command, input value, output ready);
endinterface

>>> rtl/bdq_rsp_if.sv
// Result channel of the bounded deque: both end words, count, empty flag, status.
// Depends on bdq_pkg.
`timescale 1ns / 1ps
interface bdq_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [bdq_pkg::WORD_W-1:0]   front_value;
    logic [bdq_pkg::WORD_W-1:0]   back_value;
    logic [bdq_pkg::OCNT_W-1:0]   element_count;
    logic                         is_empty;
    logic [bdq_pkg::STAT_W-1:0]   status;

    modport source (output valid, output front_value, output back_value,
                    output element_count, output is_empty, output status, input ready);
    modport sink   (input valid, input front_value, input back_value,
                    input element_count, input is_empty, input status, output ready);
endinterface

>>> rtl/bdq_cell.sv
// One storage cell of the deque row: holds a word, or takes it from a neighbor
// or from the request. Depends on bdq_pkg.
`timescale 1ns / 1ps
module bdq_cell (
    input  logic              clk,
    input  bdq_pkg::cell_op_t op,
    input  bdq_pkg::word_t    lower,
    input  bdq_pkg::word_t    upper,
    input  bdq_pkg::word_t    value,
    output bdq_pkg::word_t    data
);

    bdq_pkg::word_t data_reg;
    bdq_pkg::word_t data_next;

    always_comb
    begin
        case (op)
            bdq_pkg::CELL_FROM_LOWER: data_next = lower;
            bdq_pkg::CELL_FROM_UPPER: data_next = upper;
            bdq_pkg::CELL_LOAD:       data_next = value;
            default:                  data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

>>> rtl/bdq_chain.sv
// Row of DEPTH cells holding the queue in low-to-high order from cell 0.
// Depends on bdq_pkg and bdq_cell.
`timescale 1ns / 1ps
module bdq_chain (
    input  logic                 clk,
    input  bdq_pkg::chain_ctrl_t ctrl,
    input  bdq_pkg::word_t       value,
    output bdq_pkg::word_t       low_word,
    output bdq_pkg::word_t       high_word
);

    bdq_pkg::word_t   cell_data [bdq_pkg::DEPTH];
    bdq_pkg::cell_op_t cell_op  [bdq_pkg::DEPTH];

    for (genvar i = 0; i < bdq_pkg::DEPTH; i++)
    begin : g_cell
        bdq_pkg::word_t lower_in;
        bdq_pkg::word_t upper_in;

        // The bottom cell takes the new word when everything shifts up.
        if (i == 0)
        begin : g_bottom
            assign lower_in = value;
        end
        else
        begin : g_mid_lo
            assign lower_in = cell_data[i-1];
        end

        if (i == bdq_pkg::DEPTH - 1)
        begin : g_top
            assign upper_in = '0;
        end
        else
        begin : g_mid_hi
            assign upper_in = cell_data[i+1];
        end

        always_comb
        begin
            if (ctrl.shift_up)
                cell_op[i] = bdq_pkg::CELL_FROM_LOWER;
            else if (ctrl.shift_down)
                cell_op[i] = bdq_pkg::CELL_FROM_UPPER;
            else if (ctrl.put_high && (ctrl.put_idx == bdq_pkg::IDX_W'(i)))
                cell_op[i] = bdq_pkg::CELL_LOAD;
            else
                cell_op[i] = bdq_pkg::CELL_HOLD;
        end

        bdq_cell u_cell (
            .clk   (clk),
            .op    (cell_op[i]),
            .lower (lower_in),
            .upper (upper_in),
            .value (value),
            .data  (cell_data[i])
        );
    end

    assign low_word  = cell_data[0];
    assign high_word = cell_data[ctrl.high_idx];

endmodule

>>> rtl/bounded_deque.sv
// Bounded double-ended queue of up to DEPTH 64-bit words.
// Request channel cmd carries command and value; result channel rsp returns,
// for every request, the front and back words, the count, an empty flag and
// a status (done, overflow on add to a full queue, underflow on remove from
// an empty queue; a rejected request leaves the queue untouched).
// The words sit in a row of cells in low-to-high order; adding or removing at
// the low end shifts the whole row by one cell in that cycle, adding at the
// high end writes the cell just above the top. Reverse of a non-empty queue only
// toggles a flag that swaps which end is the front.
// The result is registered and valid in the cycle after its request is accepted.
// Throughput: one request per cycle while the receiver keeps up; the result register is the only stage.
// A request is taken while a result waits if that result leaves in the same
// cycle; while the receiver stalls, the result holds and cmd.ready is low.
// Reset clears count, direction and result valid; the cell contents are
// unknown until written and never shown for an empty queue.
// Depends on bdq_pkg, bdq_cmd_if, bdq_rsp_if, bdq_chain and the macro header.
`timescale 1ns / 1ps
`include "bounded_deque_macros.svh"
module bounded_deque (
    input  logic      clk,
    input  logic      rst_n,
    bdq_cmd_if.sink   cmd,
    bdq_rsp_if.source rsp
);

    bdq_pkg::cnt_t    count_reg;
    bdq_pkg::cnt_t    count_next;
    logic             rev_reg;
    logic             rev_next;
    logic             valid_reg;
    bdq_pkg::status_t status_reg;
    bdq_pkg::status_t status_next;

    bdq_pkg::chain_ctrl_t ctrl;
    bdq_pkg::cmd_t        cmd_code;
    bdq_pkg::word_t       low_word;
    bdq_pkg::word_t       high_word;

    logic accept;
    logic full;
    logic empty;
    logic at_low;

    assign cmd.ready = !valid_reg || rsp.ready;
    assign accept    = cmd.valid && cmd.ready;
    assign cmd_code  = bdq_pkg::cmd_t'(cmd.command);
    assign full      = (count_reg == bdq_pkg::CNT_W'(bdq_pkg::DEPTH));
    assign empty     = (count_reg == '0);

    always_comb
    begin
        count_next    = count_reg;
        rev_next      = rev_reg;
        status_next   = bdq_pkg::STATUS_DONE;
        ctrl.shift_up   = 1'b0;
        ctrl.shift_down = 1'b0;
        ctrl.put_high   = 1'b0;
        ctrl.put_idx    = bdq_pkg::IDX_W'(count_reg);
        ctrl.high_idx   = bdq_pkg::IDX_W'(count_reg - bdq_pkg::CNT_W'(1));
        // Front maps to the low end unless the order is reversed.
        at_low = ((cmd_code == bdq_pkg::CMD_ADD_FRONT) || (cmd_code == bdq_pkg::CMD_REM_FRONT))
                 ^ rev_reg;
        if (accept)
        begin
            case (cmd_code) inside
                bdq_pkg::CMD_ADD_FRONT, bdq_pkg::CMD_ADD_BACK:
                begin
                    if (full)
                        status_next = bdq_pkg::STATUS_OVERFLOW;
                    else
                    begin
                        count_next    = count_reg + bdq_pkg::CNT_W'(1);
                        ctrl.shift_up = at_low;
                        ctrl.put_high = !at_low;
                    end
                end
                bdq_pkg::CMD_REM_FRONT, bdq_pkg::CMD_REM_BACK:
                begin
                    if (empty)
                        status_next = bdq_pkg::STATUS_UNDERFLOW;
                    else
                    begin
                        count_next      = count_reg - bdq_pkg::CNT_W'(1);
                        ctrl.shift_down = at_low;
                    end
                end
                bdq_pkg::CMD_REVERSE:
                begin
                    if (!empty)
                        rev_next = !rev_reg;
                end
                bdq_pkg::CMD_CLEAR:
                begin
                    count_next = '0;
                    rev_next   = 1'b0;
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            rev_reg    <= 1'b0;
            valid_reg  <= 1'b0;
            status_reg <= bdq_pkg::STATUS_DONE;
        end
        else
        begin
            count_reg <= count_next;
            rev_reg   <= rev_next;
            if (accept)
            begin
                valid_reg  <= 1'b1;
                status_reg <= status_next;
            end
            else if (rsp.ready)
                valid_reg <= 1'b0;
        end
    end

    bdq_chain u_chain (
        .clk       (clk),
        .ctrl      (ctrl),
        .value     (cmd.value),
        .low_word  (low_word),
        .high_word (high_word)
    );

    // The state only moves on an accepted request, so the result can be read
    // straight from the registered state while it waits.
    assign rsp.valid         = valid_reg;
    assign rsp.front_value   = empty ? '0 : (rev_reg ? high_word : low_word);
    assign rsp.back_value    = empty ? '0 : (rev_reg ? low_word : high_word);
    assign rsp.element_count = bdq_pkg::OCNT_W'(count_reg);
    assign rsp.is_empty      = empty;
    assign rsp.status        = status_reg;

    `BDQ_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_reg <= bdq_pkg::CNT_W'(bdq_pkg::DEPTH), "count above depth")
    `BDQ_ASSERT_NXT(a_overflow_hold, clk, rst_n, accept && (status_next == bdq_pkg::STATUS_OVERFLOW), $stable(count_reg) && $stable(rev_reg), "overflow changed state")
    `BDQ_ASSERT_NXT(a_underflow_hold, clk, rst_n, accept && (status_next == bdq_pkg::STATUS_UNDERFLOW), $stable(count_reg) && $stable(rev_reg), "underflow changed state")
    `BDQ_ASSERT_NXT(a_result_follows, clk, rst_n, accept, valid_reg, "request without result")
    `BDQ_ASSERT_IMP(a_one_row_op, clk, rst_n, 1'b1, $onehot0({ctrl.shift_up, ctrl.shift_down, ctrl.put_high}), "conflicting row operations")

endmodule

>>> tb/sv/deque_reply_check.sv
// Reply checker for the bounded deque: mirrors the queue and compares every reply.
// Watches both channels passively; depends on bdq_pkg, bdq_cmd_if and bdq_rsp_if.
`timescale 1ns / 1ps
module deque_reply_check
    import bdq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    bdq_cmd_if   cmd,
    bdq_rsp_if   rsp,
    output int   fails,
    output int   pending,
    output int   replies,
    output int   overflows,
    output int   underflows,
    output int   peak_fill
);

    localparam int REPORT_CAP = 200;

    typedef struct packed {
        word_t               front_value;
        word_t               back_value;
        logic [OCNT_W-1:0]   element_count;
        logic                is_empty;
        status_t             status;
    } reply_t;

    // Mirror of the deque: a ring with a head index, a fill level and a direction flag.
    word_t  ring [DEPTH];
    int     head;
    int     fill;
    logic   flipped;
    reply_t awaited [$];

    function automatic reply_t apply_request(logic [CMD_W-1:0] code, word_t word);
        reply_t  outcome;
        status_t st;
        word_t   low_word;
        word_t   high_word;
        logic    at_low_end;
        st = STATUS_DONE;
        low_word = '0;
        high_word = '0;
        case (code)
            CMD_ADD_FRONT, CMD_ADD_BACK:
            begin
                // Front is the low end in natural order and the high end when reversed.
                at_low_end = (code == CMD_ADD_FRONT) ^ flipped;
                if (fill >= DEPTH)
                begin
                    st = STATUS_OVERFLOW;
                end
                else if (at_low_end)
                begin
                    head = (head + DEPTH - 1) % DEPTH;
                    ring[head] = word;
                    fill++;
                end
                else
                begin
                    ring[(head + fill) % DEPTH] = word;
                    fill++;
                end
            end
            CMD_REM_FRONT, CMD_REM_BACK:
            begin
                at_low_end = (code == CMD_REM_FRONT) ^ flipped;
                if (fill == 0)
                begin
                    st = STATUS_UNDERFLOW;
                end
                else
                begin
                    if (at_low_end)
                    begin
                        head = (head + 1) % DEPTH;
                    end
                    fill--;
                end
            end
            CMD_REVERSE:
            begin
                if (fill != 0)
                begin
                    flipped = ~flipped;
                end
            end
            CMD_CLEAR:
            begin
                head = 0;
                fill = 0;
                flipped = 1'b0;
            end
            default:
            begin
            end
        endcase
        if (fill != 0)
        begin
            low_word = ring[head];
            high_word = ring[(head + fill - 1) % DEPTH];
        end
        outcome.front_value = flipped ? high_word : low_word;
        outcome.back_value = flipped ? low_word : high_word;
        outcome.element_count = fill[OCNT_W-1:0];
        outcome.is_empty = (fill == 0);
        outcome.status = st;
        return outcome;
    endfunction

    task automatic compare_field(string field, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
        if (want !== got)
        begin
            if (fails < REPORT_CAP)
            begin
                $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
            end
            fails++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        reply_t want;
        if (!rst_n)
        begin
            head = 0;
            fill = 0;
            flipped = 1'b0;
            awaited.delete();
            fails = 0;
            pending = 0;
            replies = 0;
            overflows = 0;
            underflows = 0;
            peak_fill = 0;
        end
        else
        begin
            // The reply leaving at this edge belongs to an earlier request, so it goes first.
            if (rsp.valid && rsp.ready)
            begin
                if (awaited.size() == 0)
                begin
                    $display("%0t: reply with no request outstanding, actual front %h back %h",
                             $time, rsp.front_value, rsp.back_value);
                    fails++;
                end
                else
                begin
                    want = awaited.pop_front();
                    compare_field("front_value", want.front_value, rsp.front_value);
                    compare_field("back_value", want.back_value, rsp.back_value);
                    compare_field("element_count", want.element_count, rsp.element_count);
                    compare_field("is_empty", want.is_empty, rsp.is_empty);
                    compare_field("status", want.status, rsp.status);
                    replies++;
                end
            end
            if (cmd.valid && cmd.ready)
            begin
                want = apply_request(cmd.command, cmd.value);
                if (want.status == STATUS_OVERFLOW)
                begin
                    overflows++;
                end
                if (want.status == STATUS_UNDERFLOW)
                begin
                    underflows++;
                end
                if (fill > peak_fill)
                begin
                    peak_fill = fill;
                end
                awaited.push_back(want);
            end
            pending = awaited.size();
        end
    end

endmodule

>>> tb/sv/bounded_deque_tb.sv
// Top of the bounded deque testbench: clock, reset, request traffic and the verdict.
// Needs the RTL package, both channel interfaces, bounded_deque and deque_reply_check.
`timescale 1ns / 1ps
module bounded_deque_tb;
    import bdq_pkg::*;

    localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;
    localparam int RANDOM_REQUESTS = 1400;
    localparam int STALL_LIMIT = 1000;

    typedef enum int {FILL_UP, DRAIN, MIXED} episode_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic steady = 1'b0;
    int   sent = 0;
    int   quiet_cycles = 0;

    int fails;
    int pending;
    int replies;
    int overflows;
    int underflows;
    int peak_fill;

    bdq_cmd_if cmd_bus ();
    bdq_rsp_if rsp_bus ();

    bounded_deque uut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_bus),
        .rsp   (rsp_bus)
    );

    deque_reply_check reply_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd_bus),
        .rsp        (rsp_bus),
        .fails      (fails),
        .pending    (pending),
        .replies    (replies),
        .overflows  (overflows),
        .underflows (underflows),
        .peak_fill  (peak_fill)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        rsp_bus.ready <= steady || ($urandom_range(99) >= 15);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (cmd_bus.valid && cmd_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no request or reply moved for %0d cycles", $time, STALL_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic word_t random_word();
        int pick;
        pick = $urandom_range(99);
        if (pick < 8)
        begin
            return '1;
        end
        if (pick < 16)
        begin
            return '0;
        end
        return {$urandom, $urandom};
    endfunction

    function automatic logic [CMD_W-1:0] pick_command(episode_t mode);
        int roll;
        int add_pct;
        roll = $urandom_range(99);
        add_pct = (mode == FILL_UP) ? 70 : (mode == DRAIN) ? 15 : 42;
        // Adds and removes together take 85 percent in every episode kind.
        if (roll < add_pct)
        begin
            return $urandom_range(1) ? CMD_ADD_FRONT : CMD_ADD_BACK;
        end
        if (roll < 85)
        begin
            return $urandom_range(1) ? CMD_REM_FRONT : CMD_REM_BACK;
        end
        if (roll < 95)
        begin
            return CMD_REVERSE;
        end
        if (roll < 97)
        begin
            return CMD_CLEAR;
        end
        return $urandom_range(1) ? CMD_SPARE_HI : CMD_SPARE_LO;
    endfunction

    // Called at a rising edge; returns at the edge where the request was taken.
    task automatic issue_request(logic [CMD_W-1:0] code, word_t word);
        logic taken;
        while (!steady && $urandom_range(99) < 15)
        begin
            cmd_bus.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_bus.valid <= 1'b1;
        cmd_bus.command <= code;
        cmd_bus.value <= word;
        do
        begin
            @(negedge clk);
            taken = cmd_bus.ready;
            @(posedge clk);
        end
        while (!taken);
        sent++;
    endtask

    initial
    begin : stimulus
        episode_t mode;
        int       run_len;
        int       issued;
        cmd_bus.valid = 1'b0;
        cmd_bus.command = CMD_ADD_FRONT;
        cmd_bus.value = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // Rejected removes, reverse and a spare code while empty, then adds, a reverse and a remove.
        issue_request(CMD_REM_FRONT, '1);
        issue_request(CMD_REM_BACK, '1);
        issue_request(CMD_REVERSE, '0);
        issue_request(CMD_SPARE_LO, '1);
        issue_request(CMD_ADD_FRONT, '1);
        issue_request(CMD_ADD_BACK, '0);
        issue_request(CMD_REVERSE, '0);
        issue_request(CMD_REM_FRONT, '0);
        // Fill to the brim from both ends, then push once more against a full queue.
        for (int i = 1; i < DEPTH; i++)
        begin
            issue_request(i[0] ? CMD_ADD_FRONT : CMD_ADD_BACK, {$urandom, $urandom});
        end
        issue_request(CMD_ADD_BACK, {$urandom, $urandom});
        issue_request(CMD_SPARE_HI, '0);
        issue_request(CMD_CLEAR, '1);

        issued = 0;
        while (issued < RANDOM_REQUESTS)
        begin
            mode = episode_t'($urandom_range(2));
            run_len = $urandom_range(60, 20);
            for (int i = 0; i < run_len && issued < RANDOM_REQUESTS; i++)
            begin
                steady = (issued >= 500) && (issued < 800);
                issue_request(pick_command(mode), random_word());
                issued++;
            end
        end
        steady = 1'b0;
        cmd_bus.valid <= 1'b0;

        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);

        $display("Ran %0d requests through a %0d-deep deque; %0d replies checked.",
                 sent, DEPTH, replies);
        $display("Saw %0d overflows, %0d underflows and a peak fill of %0d.",
                 overflows, underflows, peak_fill);
        if (fails == 0 && pending == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
